// File: hdl/sorted_priority_queue_unit_macros.svh
// Assertion macros used by the priority queue RTL
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// Types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned COUNT_W = 4;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic signed [VAL_W-1:0] HEAD_EMPTY = -32'sd1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_LOAD_NEW  = 2'd1,
    OP_FROM_PREV = 2'd2,
    OP_FROM_NEXT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occupied;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: row of slot cells plus count and result
//
//  channel   direction  handshake          payload
//  command   in         start / busy       func, item_value, item_priority
//  result    out        done (one cycle)   status, taken_value, head_value, stored_count
//
// One transaction per clock: busy stays low and a command may follow every cycle.
// The result appears on the cycle after the command is taken, for exactly one cycle.
// All slots update in parallel in that edge; the insert position comes from one
// priority compare per cell, so the cell compare plus its neighbour sets the path.
// Synchronous reset empties the queue (count only); slot contents are not cleared.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  output logic                                    busy,
  input  wire                                     func,
  input  wire logic signed [spq_pkg::VAL_W-1:0]   item_value,
  input  wire logic        [spq_pkg::PRI_W-1:0]   item_priority,
  output logic                                    done,
  output logic             [1:0]                  status,
  output logic signed      [spq_pkg::VAL_W-1:0]   taken_value,
  output logic signed      [spq_pkg::VAL_W-1:0]   head_value,
  output logic             [spq_pkg::COUNT_W-1:0] stored_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic signed [spq_pkg::VAL_W-1:0] cell_value [DEPTH];
  logic        [spq_pkg::PRI_W-1:0] cell_pri   [DEPTH];
  logic                              cell_beat  [DEPTH];
  spq_pkg::cell_ctrl_t               cell_ctrl  [DEPTH];

  logic accept;
  logic push_go;
  logic pop_go;
  logic push_drop;
  logic is_full;
  logic is_empty;

  spq_pkg::status_t                 status_next;
  logic signed [spq_pkg::VAL_W-1:0] taken_next;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign push_go   = accept && (func == spq_pkg::FUNC_PUSH) && !is_full;
  assign pop_go    = accept && (func == spq_pkg::FUNC_POP) && !is_empty;
  assign push_drop = accept && (func == spq_pkg::FUNC_PUSH) && is_full;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                              prev_beat;
      logic signed [spq_pkg::VAL_W-1:0]  prev_value;
      logic        [spq_pkg::PRI_W-1:0]  prev_pri;
      logic signed [spq_pkg::VAL_W-1:0]  next_value;
      logic        [spq_pkg::PRI_W-1:0]  next_pri;

      if (i == 0) begin : g_first
        assign prev_beat  = 1'b0;
        assign prev_value = item_value;
        assign prev_pri   = item_priority;
      end else begin : g_mid
        assign prev_beat  = cell_beat[i-1];
        assign prev_value = cell_value[i-1];
        assign prev_pri   = cell_pri[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign next_value = cell_value[i];
        assign next_pri   = cell_pri[i];
      end else begin : g_inner
        assign next_value = cell_value[i+1];
        assign next_pri   = cell_pri[i+1];
      end

      always_comb begin
        cell_ctrl[i].occupied = (count > CW'(i));
        cell_ctrl[i].op       = spq_pkg::OP_HOLD;
        if (push_go && cell_beat[i]) begin
          // first beaten slot takes the newcomer, the ones below shift down
          cell_ctrl[i].op = prev_beat ? spq_pkg::OP_FROM_PREV : spq_pkg::OP_LOAD_NEW;
        end else if (pop_go) begin
          cell_ctrl[i].op = spq_pkg::OP_FROM_NEXT;
        end
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .new_value  (item_value),
        .new_pri    (item_priority),
        .prev_value (prev_value),
        .prev_pri   (prev_pri),
        .next_value (next_value),
        .next_pri   (next_pri),
        .value      (cell_value[i]),
        .pri        (cell_pri[i]),
        .beaten     (cell_beat[i])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = spq_pkg::ST_DONE;
    taken_next  = '0;
    if (push_go) begin
      count_next = count + CW'(1);
    end else if (pop_go) begin
      count_next = count - CW'(1);
      taken_next = cell_value[0];
    end else if (push_drop) begin
      status_next = spq_pkg::ST_FULL;
    end else if (accept) begin
      status_next = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      taken_value <= taken_next;
    end
  end

  // state only moves on a transaction, so these hold through the strobe cycle
  assign head_value   = is_empty ? spq_pkg::HEAD_EMPTY : cell_value[0];
  assign stored_count = spq_pkg::COUNT_W'(count);

`include "sorted_priority_queue_unit_macros.svh"

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `SPQ_ASSERT_NEXT(a_full_drop, push_drop, status == spq_pkg::ST_FULL && $stable(count), "full push kept")
  `SPQ_ASSERT_NEXT(a_pop_count, pop_go, count == $past(count) - CW'(1), "pop did not remove one entry")
  `SPQ_ASSERT_NEXT(a_done_follows, !accept, !done, "result strobe without a transaction")

endmodule

`default_nettype wire

// File: hdl/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbours
`default_nettype none

module spq_cell (
  input  wire                                     clk,
  input  wire spq_pkg::cell_ctrl_t                ctrl,
  input  wire logic signed [spq_pkg::VAL_W-1:0]   new_value,
  input  wire logic        [spq_pkg::PRI_W-1:0]   new_pri,
  input  wire logic signed [spq_pkg::VAL_W-1:0]   prev_value,
  input  wire logic        [spq_pkg::PRI_W-1:0]   prev_pri,
  input  wire logic signed [spq_pkg::VAL_W-1:0]   next_value,
  input  wire logic        [spq_pkg::PRI_W-1:0]   next_pri,
  output logic signed      [spq_pkg::VAL_W-1:0]   value,
  output logic             [spq_pkg::PRI_W-1:0]   pri,
  output logic                                    beaten
);

  // Newcomer belongs here or further up if this slot is free or ranks lower
  assign beaten = !ctrl.occupied || (new_pri > pri);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      spq_pkg::OP_LOAD_NEW: begin
        value <= new_value;
        pri   <= new_pri;
      end
      spq_pkg::OP_FROM_PREV: begin
        value <= prev_value;
        pri   <= prev_pri;
      end
      spq_pkg::OP_FROM_NEXT: begin
        value <= next_value;
        pri   <= next_pri;
      end
      default: begin
        value <= value;
        pri   <= pri;
      end
    endcase
  end

endmodule

`default_nettype wire
